FILE: rtl/cfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_pkg: shared types and constants
// Frame bytes, command codes, event kinds, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int ROWS         = (BUFFER_DEPTH + 1) / 2;
  localparam int ROW_W        = $clog2(ROWS);
  localparam int CFG_W        = 6;
  localparam int CMP_W        = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [7:0] START_BYTE = 8'h24;
  localparam logic [7:0] END_BYTE   = 8'h21;
  localparam logic [7:0] CMD_CAL    = 8'h31;
  localparam logic [7:0] CMD_ARM    = 8'h32;
  localparam logic [7:0] CMD_REF    = 8'h33;
  localparam logic [7:0] CMD_GAIN   = 8'h34;
  localparam logic [7:0] CMD_SAVE   = 8'h35;

  localparam logic [3:0] REF_LAST   = 4'd3;
  localparam logic [3:0] GAIN_LAST  = 4'd12;

  localparam logic [CFG_W-1:0] REF_LEN_RESET = 6'd11;

  typedef enum logic [2:0] {
    EV_CAL     = 3'd0,
    EV_ARM     = 3'd1,
    EV_REF     = 3'd2,
    EV_LEN_ERR = 3'd3,
    EV_GAIN    = 3'd4,
    EV_SAVE    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SINGLE,
    ACT_WORDS
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SINGLE,
    ST_READ,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic latch;
    logic rd_en;
    logic load_single;
    logic load_word;
    logic inc_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic close;
    act_t act;
    logic last_word;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/cfp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_ctrl: frame parser controller
// Accepts bytes while idle, decodes a closed frame and sequences the
// buffer reads and result loads.
// ----------------------------------------------------------------------------
module cfp_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  cfp_pkg::dp_status_t status,
  output cfp_pkg::dp_cmd_t    cmd
);

  cfp_pkg::state_t state;
  cfp_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cfp_pkg::ST_IDLE: begin
        if (in_valid && status.close) state_next = cfp_pkg::ST_DECODE;
      end
      cfp_pkg::ST_DECODE: begin
        unique case (status.act)
          cfp_pkg::ACT_SINGLE: state_next = cfp_pkg::ST_SINGLE;
          cfp_pkg::ACT_WORDS:  state_next = cfp_pkg::ST_READ;
          default:             state_next = cfp_pkg::ST_IDLE;
        endcase
      end
      cfp_pkg::ST_SINGLE: begin
        if (status.out_free) state_next = cfp_pkg::ST_IDLE;
      end
      cfp_pkg::ST_READ: begin
        state_next = cfp_pkg::ST_EMIT;
      end
      cfp_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_next = status.last_word ? cfp_pkg::ST_IDLE : cfp_pkg::ST_READ;
        end
      end
      default: state_next = cfp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      cfp_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      cfp_pkg::ST_DECODE: begin
        cmd.latch = 1'b1;
      end
      cfp_pkg::ST_SINGLE: begin
        cmd.load_single = status.out_free;
      end
      cfp_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      cfp_pkg::ST_EMIT: begin
        cmd.load_word = status.out_free;
        cmd.inc_idx   = status.out_free && !status.last_word;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/cfp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfp_datapath: frame buffer and result register
// Byte count, command capture, the frame buffer as a word-wide memory
// with byte lanes and per-byte valid bits, and the output register.
// ----------------------------------------------------------------------------
module cfp_datapath (
  input  wire                         clk,
  input  wire                         rst,
  input  wire  [7:0]                  rx_byte,
  input  wire  [cfp_pkg::CFG_W-1:0]   ref_len,
  input  cfp_pkg::dp_cmd_t            cmd,
  output cfp_pkg::dp_status_t         status,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic [2:0]                  event_kind,
  output logic [3:0]                  value_index,
  output logic [15:0]                 value_word,
  output logic                        last_of_frame
);

  logic [cfp_pkg::CNT_W-1:0] count;
  logic [cfp_pkg::CNT_W-1:0] count_next;
  logic [cfp_pkg::CNT_W-1:0] frame_len;
  logic [7:0]                cmd_byte;

  logic                      is_start;
  logic                      wr_en;
  logic                      close;
  logic [cfp_pkg::CNT_W-1:0] wr_pos;
  logic [cfp_pkg::ROW_W-1:0] wr_row;

  logic [15:0]               mem [cfp_pkg::ROWS];
  logic [cfp_pkg::ROWS-1:0]  vld_hi;
  logic [cfp_pkg::ROWS-1:0]  vld_lo;
  logic [15:0]               rd_data;
  logic [1:0]                rd_vld;
  logic [cfp_pkg::ROW_W-1:0] rd_row;

  logic [3:0]                idx;
  logic [3:0]                idx_last;
  cfp_pkg::event_t           kind;
  cfp_pkg::event_t           kind_sel;
  cfp_pkg::act_t             act_sel;
  logic [3:0]                last_sel;
  logic                      len_match;
  logic                      out_free;

  // byte intake
  always_comb begin
    is_start   = (rx_byte == cfp_pkg::START_BYTE);
    wr_en      = 1'b0;
    close      = 1'b0;
    wr_pos     = count;
    count_next = count;
    if (is_start) begin
      wr_en      = 1'b1;
      wr_pos     = '0;
      count_next = cfp_pkg::CNT_W'(1);
    end else if (count == '0) begin
      count_next = count;
    end else if (count >= cfp_pkg::CNT_W'(cfp_pkg::BUFFER_DEPTH)) begin
      count_next = '0;
    end else begin
      wr_en = 1'b1;
      if (rx_byte == cfp_pkg::END_BYTE) begin
        close      = 1'b1;
        count_next = '0;
      end else begin
        count_next = count + cfp_pkg::CNT_W'(1);
      end
    end
  end

  assign wr_row = cfp_pkg::ROW_W'(wr_pos >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en && (wr_pos == cfp_pkg::CNT_W'(1))) cmd_byte <= rx_byte;
    if (cmd.accept && close) frame_len <= count + cfp_pkg::CNT_W'(1);
  end

  // frame buffer: even byte in the upper lane
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      if (!wr_pos[0]) begin
        mem[wr_row][15:8] <= rx_byte;
      end else begin
        mem[wr_row][7:0] <= rx_byte;
      end
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_row];
      rd_vld  <= {vld_hi[rd_row], vld_lo[rd_row]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_hi <= '0;
      vld_lo <= '0;
    end else if (cmd.accept && wr_en) begin
      if (!wr_pos[0]) begin
        vld_hi[wr_row] <= 1'b1;
      end else begin
        vld_lo[wr_row] <= 1'b1;
      end
    end
  end

  assign rd_row = cfp_pkg::ROW_W'(idx + 4'd1);

  // command decode
  assign len_match = (cfp_pkg::CMP_W'(frame_len) == cfp_pkg::CMP_W'(ref_len));

  always_comb begin
    kind_sel = cfp_pkg::EV_CAL;
    act_sel  = cfp_pkg::ACT_NONE;
    last_sel = '0;
    unique case (cmd_byte)
      cfp_pkg::CMD_CAL: begin
        kind_sel = cfp_pkg::EV_CAL;
        act_sel  = cfp_pkg::ACT_SINGLE;
      end
      cfp_pkg::CMD_ARM: begin
        kind_sel = cfp_pkg::EV_ARM;
        act_sel  = cfp_pkg::ACT_SINGLE;
      end
      cfp_pkg::CMD_REF: begin
        if (len_match) begin
          kind_sel = cfp_pkg::EV_REF;
          act_sel  = cfp_pkg::ACT_WORDS;
          last_sel = cfp_pkg::REF_LAST;
        end else begin
          kind_sel = cfp_pkg::EV_LEN_ERR;
          act_sel  = cfp_pkg::ACT_SINGLE;
        end
      end
      cfp_pkg::CMD_GAIN: begin
        kind_sel = cfp_pkg::EV_GAIN;
        act_sel  = cfp_pkg::ACT_WORDS;
        last_sel = cfp_pkg::GAIN_LAST;
      end
      cfp_pkg::CMD_SAVE: begin
        kind_sel = cfp_pkg::EV_SAVE;
        act_sel  = cfp_pkg::ACT_SINGLE;
      end
      default: begin
        act_sel = cfp_pkg::ACT_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind     <= kind_sel;
      idx_last <= last_sel;
      idx      <= '0;
    end else if (cmd.inc_idx) begin
      idx <= idx + 4'd1;
    end
  end

  // result register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_single || cmd.load_word) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_single) begin
      event_kind    <= kind;
      value_index   <= '0;
      value_word    <= '0;
      last_of_frame <= 1'b1;
    end else if (cmd.load_word) begin
      event_kind    <= kind;
      value_index   <= idx;
      value_word    <= {rd_vld[1] ? rd_data[15:8] : 8'h00,
                        rd_vld[0] ? rd_data[7:0]  : 8'h00};
      last_of_frame <= (idx == idx_last);
    end
  end

  always_comb begin
    status.close     = close;
    status.act       = act_sel;
    status.last_word = (idx == idx_last);
    status.out_free  = out_free;
  end

endmodule
`default_nettype wire

FILE: rtl/command_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// command_frame_parser: serial command frame parser
// Input channel: one received byte per word (in_valid/in_stall, rx_byte).
// Output channel: result words (out_valid/out_stall, event_kind,
// value_index, value_word, last_of_frame), one output register deep.
// A closing byte moves the controller to decode; calibrate, arm, save
// and length error then load one result from the single-result state.
// Reference and gain frames read one buffer row per result through the
// single read port, in a read state then an emit state, for N results
// with N = 4 or 13.
// in_stall is high while a frame's results are being produced.
// When the receiver stalls, the output register holds its word and the
// sequence waits; bytes are taken again once the last result is loaded.
// Reset clears the byte count, the buffer valid bits (buffer reads as
// zero until written) and sets reference_frame_length to 11.
// The register is written over the APB port at byte addresses 0 to 3.
// ----------------------------------------------------------------------------
module command_frame_parser (
  input  wire         clk,
  input  wire         rst,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  rx_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  event_kind,
  output logic [3:0]  value_index,
  output logic [15:0] value_word,
  output logic        last_of_frame
);

  logic [cfp_pkg::CFG_W-1:0] reference_frame_length;
  cfp_pkg::dp_cmd_t          cmd;
  cfp_pkg::dp_status_t       status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_frame_length <= cfp_pkg::REF_LEN_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      reference_frame_length <= pwdata[cfp_pkg::CFG_W-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : 32'(reference_frame_length);

  cfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  cfp_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .rx_byte       (rx_byte),
    .ref_len       (reference_frame_length),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind    (event_kind),
    .value_index   (value_index),
    .value_word    (value_word),
    .last_of_frame (last_of_frame)
  );

endmodule
`default_nettype wire
